[hw/rtl/mal_pkg.sv]
// ----------------------------------------------------------------------------
// mal_pkg
// Shared types and codes of the model admission and eviction block.
// ----------------------------------------------------------------------------
package mal_pkg;

   typedef enum logic [1:0] {
      OP_ADMIT  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_UNLOAD = 2'd2,
      OP_EVICT  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_RAM_LIMIT  = 3'd0,
      CSR_VRAM_LIMIT = 3'd1,
      CSR_LOW_PCT    = 3'd2,
      CSR_NO_PCT     = 3'd3,
      CSR_RSV_PCT    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      RSN_NONE     = 3'd0,
      RSN_NO_CAP   = 3'd1,
      RSN_NO_RAM   = 3'd2,
      RSN_RAM_LOW  = 3'd3,
      RSN_VRAM_LOW = 3'd4
   } reason_type;

   typedef enum logic [1:0] {
      PRS_AVAILABLE = 2'd0,
      PRS_LOW       = 2'd1,
      PRS_NO_RAM    = 2'd2
   } pressure_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_DISPATCH,
      ST_FIT,
      ST_LRU,
      ST_LRU_END,
      ST_NOTICE,
      ST_FINAL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // latch the request item
      logic scan_rst;   // restart the slot scan
      logic scan_find;  // one step of the id lookup scan
      logic scan_lru;   // one step of the idle LRU scan
      logic apply;      // carry out touch, load or unload
      logic remove;     // drop the captured slot and send its notice
      logic out_final;  // send the final result
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type op;
      logic       scan_done;
      logic       found;
      logic       hit;
      logic       fits;
      logic       out_free;
   } dp_sts_type;

   localparam int unsigned RamW  = 20;
   localparam int unsigned PctW  = 7;
   localparam int unsigned RefsW = 8;
   localparam int unsigned TagW  = 32;

endpackage

[hw/rtl/model_admission_lru_evictor_top.sv]
// ----------------------------------------------------------------------------
// model_admission_lru_evictor_top
// Resident model table with watermark admission and LRU eviction.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream, one item each: admit, mark loaded,
// mark unloaded or evict. Each request gives zero or more eviction notice
// items (rsp_tlast low, carrying the evicted id and process tag) followed by
// one final item (rsp_tlast high) with verdict, pressure, reason and status.
// The csr_ port writes the RAM and VRAM budgets and percent thresholds. The
// user must write it only while no request is in progress; the block itself
// does not enforce this. One request is handled at a time. The id lookup
// walks the slot table one entry per cycle, and every eviction on admit adds
// another table walk for the oldest idle model. The result register holds an
// item while the receiver stalls and the sequencer waits on it before issuing
// the next. Reset empties the table (valid bits and size sums cleared at
// once) and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module model_admission_lru_evictor_top
   import mal_pkg::*;
#(
   parameter int MODEL_SLOTS = 32,
   parameter int ID_BITS     = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [19:0]   csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // opcode, model_id, niceness, ram_need, vram_need, process_tag, now
   input  logic [127:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // evicted_id, evicted_tag, allowed, pressure, reason_code, status, pad
   output logic [55:0]   rsp_tdata,
   output logic          rsp_tlast
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   mal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mal_dp #(
      .MODEL_SLOTS (MODEL_SLOTS),
      .ID_BITS     (ID_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

[hw/rtl/mal_ctrl.sv]
// ----------------------------------------------------------------------------
// mal_ctrl
// Sequencer: lookup scan, eviction loop and result issue.
// ----------------------------------------------------------------------------
module mal_ctrl
   import mal_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FIND;
         end
         ST_FIND: begin
            if (sts.scan_done) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (sts.op)
               OP_ADMIT: state_in = sts.found ? ST_FINAL : ST_FIT;
               OP_EVICT: state_in = sts.found ? ST_NOTICE : ST_FINAL;
               default:  state_in = ST_FINAL;
            endcase
         end
         ST_FIT: begin
            state_in = sts.fits ? ST_FINAL : ST_LRU;
         end
         ST_LRU: begin
            if (sts.scan_done) state_in = ST_LRU_END;
         end
         ST_LRU_END: begin
            state_in = sts.hit ? ST_NOTICE : ST_FINAL;
         end
         ST_NOTICE: begin
            if (sts.out_free) state_in = (sts.op == OP_ADMIT) ? ST_FIT : ST_FINAL;
         end
         ST_FINAL: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.take     = req_tvalid;
            cmd.scan_rst = req_tvalid;
         end
         ST_FIND: begin
            cmd.scan_find = 1'b1;
         end
         ST_DISPATCH: begin
            cmd.apply = (sts.op == OP_LOAD) || (sts.op == OP_UNLOAD) ||
                        ((sts.op == OP_ADMIT) && sts.found);
         end
         ST_FIT: begin
            cmd.scan_rst = !sts.fits;
         end
         ST_LRU: begin
            cmd.scan_lru = 1'b1;
         end
         ST_NOTICE: begin
            cmd.remove = sts.out_free;
         end
         ST_FINAL: begin
            cmd.out_final = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hw/rtl/mal_dp.sv]
// ----------------------------------------------------------------------------
// mal_dp
// Slot table, running size sums, threshold checks and result register.
// ----------------------------------------------------------------------------
module mal_dp
   import mal_pkg::*;
#(
   parameter int MODEL_SLOTS = 32,
   parameter int ID_BITS     = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [19:0]   csr_wdata,
   input  logic [127:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,
   output logic          rsp_tlast,
   input  dp_cmd_type    cmd,
   output dp_sts_type    sts
);

   localparam int SlotW = (MODEL_SLOTS > 1) ? $clog2(MODEL_SLOTS) : 1;
   localparam int IdW   = (ID_BITS < 16) ? ID_BITS : 16;
   localparam int SumW  = RamW + $clog2(MODEL_SLOTS + 1);
   localparam int PW    = SumW + 10;

   // configuration
   logic [RamW-1:0] ram_lim_ff, vram_lim_ff;
   logic [PctW-1:0] low_pct_ff, no_pct_ff, rsv_pct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_lim_ff  <= RamW'(16384);
         vram_lim_ff <= '0;
         low_pct_ff  <= PctW'(20);
         no_pct_ff   <= PctW'(8);
         rsv_pct_ff  <= PctW'(10);
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAM_LIMIT:  ram_lim_ff  <= csr_wdata;
            CSR_VRAM_LIMIT: vram_lim_ff <= csr_wdata;
            CSR_LOW_PCT:    low_pct_ff  <= csr_wdata[PctW-1:0];
            CSR_NO_PCT:     no_pct_ff   <= csr_wdata[PctW-1:0];
            CSR_RSV_PCT:    rsv_pct_ff  <= csr_wdata[PctW-1:0];
            default: ;
         endcase
      end
   end

   // request item
   opcode_type      op_ff;
   logic [IdW-1:0]  id_ff;
   logic [5:0]      nice_ff;
   logic [RamW-1:0] ram_ff, vram_ff;
   logic [TagW-1:0] tag_ff, now_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff   <= opcode_type'(req_tdata[1:0]);
         id_ff   <= req_tdata[2 +: IdW];
         nice_ff <= req_tdata[23:18];
         ram_ff  <= req_tdata[43:24];
         vram_ff <= req_tdata[63:44];
         tag_ff  <= req_tdata[95:64];
         now_ff  <= req_tdata[127:96];
      end
   end

   // slot table
   logic [MODEL_SLOTS-1:0] valid_ff;
   logic [IdW-1:0]   t_id   [MODEL_SLOTS];
   logic [RamW-1:0]  t_ram  [MODEL_SLOTS];
   logic [RamW-1:0]  t_vram [MODEL_SLOTS];
   logic [RefsW-1:0] t_refs [MODEL_SLOTS];
   logic [TagW-1:0]  t_lu   [MODEL_SLOTS];
   logic [TagW-1:0]  t_tag  [MODEL_SLOTS];

   logic [SlotW-1:0] idx_ff;
   logic             found_ff, hit_ff, free_ff, status_ff;
   logic [SlotW-1:0] hit_idx_ff, free_idx_ff;
   logic [IdW-1:0]   hit_id_ff;
   logic [TagW-1:0]  hit_tag_ff, hit_lu_ff;
   logic [RamW-1:0]  hit_ram_ff, hit_vram_ff;
   logic [RefsW-1:0] hit_refs_ff;
   logic [SumW-1:0]  sum_ram_ff, sum_vram_ff;

   logic             s_valid, cap_find, cap_lru, is_free;
   logic [SlotW-1:0] waddr;

   assign s_valid  = valid_ff[idx_ff];
   assign cap_find = cmd.scan_find && s_valid && !found_ff && (t_id[idx_ff] == id_ff);
   assign cap_lru  = cmd.scan_lru && s_valid && (t_refs[idx_ff] == '0) &&
                     (!hit_ff || (t_lu[idx_ff] < hit_lu_ff));
   assign is_free  = cmd.scan_find && !s_valid && !free_ff;
   assign waddr    = found_ff ? hit_idx_ff : free_idx_ff;

   always_ff @(posedge clock) begin
      if (cap_find || cap_lru) begin
         hit_idx_ff  <= idx_ff;
         hit_id_ff   <= t_id[idx_ff];
         hit_tag_ff  <= t_tag[idx_ff];
         hit_lu_ff   <= t_lu[idx_ff];
         hit_ram_ff  <= t_ram[idx_ff];
         hit_vram_ff <= t_vram[idx_ff];
         hit_refs_ff <= t_refs[idx_ff];
      end
      if (is_free) free_idx_ff <= idx_ff;
      if (cmd.apply) begin
         if (found_ff) begin
            t_lu[waddr] <= now_ff;
            if (op_ff == OP_LOAD) begin
               t_tag[waddr] <= tag_ff;
               if (hit_refs_ff != '1) t_refs[waddr] <= hit_refs_ff + RefsW'(1);
            end else if (op_ff == OP_UNLOAD) begin
               if (hit_refs_ff != '0) t_refs[waddr] <= hit_refs_ff - RefsW'(1);
            end
         end else if (op_ff == OP_LOAD && free_ff) begin
            t_id[waddr]   <= id_ff;
            t_ram[waddr]  <= ram_ff;
            t_vram[waddr] <= vram_ff;
            t_refs[waddr] <= RefsW'(1);
            t_lu[waddr]   <= now_ff;
            t_tag[waddr]  <= tag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         idx_ff      <= '0;
         found_ff    <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         status_ff   <= 1'b0;
         sum_ram_ff  <= '0;
         sum_vram_ff <= '0;
      end else begin
         if (cmd.take) begin
            found_ff  <= 1'b0;
            free_ff   <= 1'b0;
            status_ff <= 1'b0;
         end
         if (cmd.scan_rst) begin
            idx_ff <= '0;
            hit_ff <= 1'b0;
         end else if (cmd.scan_find || cmd.scan_lru) begin
            idx_ff <= idx_ff + SlotW'(1);
         end
         if (cap_find) begin
            found_ff <= 1'b1;
            hit_ff   <= 1'b1;
         end
         if (cap_lru) hit_ff <= 1'b1;
         if (is_free) free_ff <= 1'b1;
         if (cmd.apply && !found_ff && op_ff == OP_LOAD) begin
            if (free_ff) begin
               valid_ff[free_idx_ff] <= 1'b1;
               sum_ram_ff  <= sum_ram_ff + SumW'(ram_ff);
               sum_vram_ff <= sum_vram_ff + SumW'(vram_ff);
            end else begin
               status_ff <= 1'b1;
            end
         end
         if (cmd.remove) begin
            valid_ff[hit_idx_ff] <= 1'b0;
            sum_ram_ff  <= sum_ram_ff - SumW'(hit_ram_ff);
            sum_vram_ff <= sum_vram_ff - SumW'(hit_vram_ff);
         end
      end
   end

   // capacity and pressure checks
   logic [RamW-1:0]  total;
   logic [RamW-1:0]  req_ram;
   logic             admit_new, vram_on, nice_pos, nice_ge10, fits;
   logic signed [PW-1:0] rem_s, rem100, thr_no, thr_low;
   logic [PW-1:0]    v_lhs, v_rhs;
   pressure_type     prs;
   reason_type       rsn;
   logic             allowed;

   assign total     = (ram_lim_ff == '0) ? RamW'(1) : ram_lim_ff;
   assign admit_new = (op_ff == OP_ADMIT) && !found_ff;
   assign req_ram   = admit_new ? ram_ff : '0;
   assign vram_on   = (vram_ff != '0) && (vram_lim_ff != '0);
   assign nice_pos  = !nice_ff[5] && (nice_ff != '0);
   assign nice_ge10 = $signed(nice_ff) >= 6'sd10;
   assign fits      = ((SumW+1)'(sum_ram_ff) + (SumW+1)'(ram_ff) <= (SumW+1)'(total)) &&
                      !(vram_on && ((SumW+1)'(sum_vram_ff) + (SumW+1)'(vram_ff) >
                                    (SumW+1)'(vram_lim_ff)));

   always_comb begin
      rem_s   = $signed(PW'(total) - PW'(sum_ram_ff) - PW'(req_ram));
      rem100  = rem_s * $signed(PW'(100));
      thr_no  = $signed(PW'(no_pct_ff) * PW'(total));
      thr_low = $signed(PW'(low_pct_ff) * PW'(total));
      if (rem100 < thr_no) prs = PRS_NO_RAM;
      else if (rem100 < thr_low) prs = PRS_LOW;
      else prs = PRS_AVAILABLE;
      v_lhs = (PW'(sum_vram_ff) + PW'(vram_ff)) * PW'(100) +
              PW'(vram_lim_ff) * PW'(rsv_pct_ff);
      v_rhs = PW'(vram_lim_ff) * PW'(100);
      rsn = RSN_NONE;
      if (admit_new) begin
         if (!fits) rsn = RSN_NO_CAP;
         else if (prs == PRS_NO_RAM && nice_pos) rsn = RSN_NO_RAM;
         else if (prs == PRS_LOW && nice_ge10) rsn = RSN_RAM_LOW;
         else if (vram_on && nice_pos && (v_lhs > v_rhs)) rsn = RSN_VRAM_LOW;
      end
      allowed = (op_ff == OP_ADMIT) && (found_ff || rsn == RSN_NONE);
   end

   // result register
   logic        out_valid_ff;
   logic [55:0] out_data_ff;
   logic        out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.remove || cmd.out_final) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.remove) begin
         out_data_ff <= {1'b0, 1'b0, 3'd0, 2'd0, 1'b0, hit_tag_ff, 16'(hit_id_ff)};
         out_last_ff <= 1'b0;
      end else if (cmd.out_final) begin
         out_data_ff <= {1'b0, status_ff, rsn, prs, allowed, 32'd0, 16'd0};
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   assign sts.op        = op_ff;
   assign sts.scan_done = (idx_ff == SlotW'(MODEL_SLOTS - 1));
   assign sts.found     = found_ff;
   assign sts.hit       = hit_ff;
   assign sts.fits      = fits;
   assign sts.out_free  = !out_valid_ff || rsp_tready;

endmodule
